[hdl/ppp_pkg.sv]
// shared types and constants for the perspective point projection core
package ppp_pkg;

   // fixed field widths of the configuration registers
   localparam int TRIG_BITS   = 16;
   localparam int FOCAL_BITS  = 24;
   localparam int GAIN_BITS   = 16;
   localparam int CENTER_BITS = 16;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;

   // quotient bits of the divider; larger quotients clamp, which saturates anyway
   localparam int QUOT_BITS = 26;

   // register indexes, one register every eight bytes
   typedef enum logic [2:0] {
      REG_VIEW_TRIG     = 3'd0,
      REG_ORIGIN_EAST   = 3'd1,
      REG_ORIGIN_NORTH  = 3'd2,
      REG_ORIGIN_HEIGHT = 3'd3,
      REG_FOCAL_SCALE   = 3'd4,
      REG_SCREEN_CENTER = 3'd5,
      REG_HEIGHT_GAIN   = 3'd6,
      REG_DRAW_NULL     = 3'd7
   } reg_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_PROJECTED = 2'd0,
      STATUS_NULL      = 2'd1,
      STATUS_DEPTH     = 2'd2
   } status_type;

   // side information that travels alongside the divider
   typedef struct packed {
      status_type status;
      logic       neg_x;
      logic       neg_y;
   } side_type;

endpackage

[hdl/ppp_csr.sv]
// configuration register file with apb-style access
module ppp_csr
   import ppp_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready,
   output logic [63:0]               view_trig,
   output logic [COORD_BITS-1:0]     origin_east,
   output logic [COORD_BITS-1:0]     origin_north,
   output logic [COORD_BITS-1:0]     origin_height,
   output logic [FOCAL_BITS-1:0]     focal_scale,
   output logic [31:0]               screen_center,
   output logic [GAIN_BITS-1:0]      height_gain,
   output logic                      draw_null
);

   logic [63:0]            view_trig_ff;
   logic [COORD_BITS-1:0]  origin_east_ff;
   logic [COORD_BITS-1:0]  origin_north_ff;
   logic [COORD_BITS-1:0]  origin_height_ff;
   logic [FOCAL_BITS-1:0]  focal_scale_ff;
   logic [31:0]            screen_center_ff;
   logic [GAIN_BITS-1:0]   height_gain_ff;
   logic                   draw_null_ff;
   logic                   wr_en;
   reg_index_type          idx;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx   = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:3]);
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         view_trig_ff     <= 64'h4000_0000_4000_0000;
         origin_east_ff   <= '0;
         origin_north_ff  <= '0;
         origin_height_ff <= '0;
         focal_scale_ff   <= FOCAL_BITS'(256);
         screen_center_ff <= '0;
         height_gain_ff   <= GAIN_BITS'(256);
         draw_null_ff     <= 1'b0;
      end else if (wr_en) begin
         case (idx)
            REG_VIEW_TRIG:     view_trig_ff     <= csr_pwdata;
            REG_ORIGIN_EAST:   origin_east_ff   <= csr_pwdata[COORD_BITS-1:0];
            REG_ORIGIN_NORTH:  origin_north_ff  <= csr_pwdata[COORD_BITS-1:0];
            REG_ORIGIN_HEIGHT: origin_height_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_FOCAL_SCALE:   focal_scale_ff   <= csr_pwdata[FOCAL_BITS-1:0];
            REG_SCREEN_CENTER: screen_center_ff <= csr_pwdata[31:0];
            REG_HEIGHT_GAIN:   height_gain_ff   <= csr_pwdata[GAIN_BITS-1:0];
            REG_DRAW_NULL:     draw_null_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_VIEW_TRIG:     csr_prdata = view_trig_ff;
         REG_ORIGIN_EAST:   csr_prdata = CSR_DATA_BITS'(origin_east_ff);
         REG_ORIGIN_NORTH:  csr_prdata = CSR_DATA_BITS'(origin_north_ff);
         REG_ORIGIN_HEIGHT: csr_prdata = CSR_DATA_BITS'(origin_height_ff);
         REG_FOCAL_SCALE:   csr_prdata = CSR_DATA_BITS'(focal_scale_ff);
         REG_SCREEN_CENTER: csr_prdata = CSR_DATA_BITS'(screen_center_ff);
         REG_HEIGHT_GAIN:   csr_prdata = CSR_DATA_BITS'(height_gain_ff);
         REG_DRAW_NULL:     csr_prdata = CSR_DATA_BITS'(draw_null_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign view_trig     = view_trig_ff;
   assign origin_east   = origin_east_ff;
   assign origin_north  = origin_north_ff;
   assign origin_height = origin_height_ff;
   assign focal_scale   = focal_scale_ff;
   assign screen_center = screen_center_ff;
   assign height_gain   = height_gain_ff;
   assign draw_null     = draw_null_ff;

endmodule

[hdl/ppp_front.sv]
// geometry stages: height gain, eye offset, yaw and pitch rotation
module ppp_front
   import ppp_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [COORD_BITS-1:0]  east,
   input  logic signed [COORD_BITS-1:0]  north,
   input  logic signed [COORD_BITS-1:0]  height,
   input  logic                          height_null,
   input  logic [63:0]                   view_trig,
   input  logic [COORD_BITS-1:0]         origin_east,
   input  logic [COORD_BITS-1:0]         origin_north,
   input  logic [COORD_BITS-1:0]         origin_height,
   input  logic [GAIN_BITS-1:0]          height_gain,
   input  logic                          draw_null,
   output logic                          out_valid,
   output logic signed [COORD_BITS+1:0]  lat_out,
   output logic signed [COORD_BITS+3:0]  vert_out,
   output logic signed [COORD_BITS+3:0]  depth_out,
   output status_type                    status_out
);

   localparam int C  = COORD_BITS;
   localparam int WW = C + 10;
   localparam int PW = C + 18;
   localparam logic signed [WW-1:0] SAT_HI = WW'((64'd1 << (C - 1)) - 64'd1);
   localparam logic signed [WW-1:0] SAT_LO = -SAT_HI;
   localparam logic signed [PW-1:0] Q14_RND = PW'(16383);

   // truncate toward zero after a q2.14 product
   function automatic logic signed [PW-1:0] trunc_q14(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = p[PW-1] ? (p + Q14_RND) : p;
      return t >>> 14;
   endfunction

   // symmetric clamp to coordinate width
   function automatic logic signed [C-1:0] sat_coord(input logic signed [WW-1:0] x);
      logic signed [WW-1:0] r;
      r = x;
      if (x > SAT_HI) r = SAT_HI;
      if (x < SAT_LO) r = SAT_LO;
      return r[C-1:0];
   endfunction

   logic signed [TRIG_BITS-1:0] cos_p, sin_p, cos_y, sin_y;
   assign cos_p = view_trig[63:48];
   assign sin_p = view_trig[47:32];
   assign cos_y = view_trig[31:16];
   assign sin_y = view_trig[15:0];

   // stage 1: height magnitude times gain
   logic                   s1_vld_ff;
   logic signed [C-1:0]    s1_east_ff, s1_north_ff;
   logic [C+15:0]          s1_hprod_ff, s1_hprod_in;
   logic                   s1_hneg_ff, s1_hneg_in;
   status_type             s1_stat_ff, s1_stat_in;
   logic [C-1:0]           hmag;

   always_comb begin
      hmag        = height_null ? '0 : (height[C-1] ? (~height + 1'b1) : height);
      s1_hneg_in  = !height_null && height[C-1];
      s1_hprod_in = (C+16)'(hmag) * (C+16)'(height_gain);
      s1_stat_in  = (height_null && !draw_null) ? STATUS_NULL : STATUS_PROJECTED;
   end

   // stage 2: offsets from the eye, saturated
   logic                   s2_vld_ff;
   logic signed [C-1:0]    s2_de_ff, s2_dn_ff, s2_dh_ff;
   logic signed [C-1:0]    s2_de_in, s2_dn_in, s2_dh_in;
   status_type             s2_stat_ff;
   logic signed [WW-1:0]   h_s, de_w, dn_w, dh_w, oe_w, on_w, oh_w, e_w, n_w;
   logic [C+7:0]           hshift;

   always_comb begin
      hshift = s1_hprod_ff[C+15:8];
      h_s    = s1_hneg_ff ? -$signed({2'b00, hshift}) : $signed({2'b00, hshift});
      oe_w   = $signed(origin_east);
      on_w   = $signed(origin_north);
      oh_w   = $signed(origin_height);
      e_w    = s1_east_ff;
      n_w    = s1_north_ff;
      de_w   = e_w - oe_w;
      dn_w   = n_w - on_w;
      dh_w   = h_s - oh_w;
      s2_de_in = sat_coord(de_w);
      s2_dn_in = sat_coord(dn_w);
      s2_dh_in = sat_coord(dh_w);
   end

   // stage 3: yaw products
   logic                    s3_vld_ff;
   logic signed [C+15:0]    s3_pes_ff, s3_pnc_ff, s3_pec_ff, s3_pns_ff;
   logic signed [C-1:0]     s3_dh_ff;
   status_type              s3_stat_ff;

   // stage 4: yaw sums
   logic                    s4_vld_ff;
   logic signed [C+1:0]     s4_u_ff, s4_v_ff, s4_u_in, s4_v_in;
   logic signed [C-1:0]     s4_dh_ff;
   status_type              s4_stat_ff;
   logic signed [PW-1:0]    a_pes, a_pnc, a_pec, a_pns, u_full, v_full;

   always_comb begin
      a_pes  = s3_pes_ff;
      a_pnc  = s3_pnc_ff;
      a_pec  = s3_pec_ff;
      a_pns  = s3_pns_ff;
      u_full = trunc_q14(a_pes) + trunc_q14(a_pnc);
      v_full = trunc_q14(a_pec) - trunc_q14(a_pns);
      s4_u_in = u_full[C+1:0];
      s4_v_in = v_full[C+1:0];
   end

   // stage 5: pitch products
   logic                    s5_vld_ff;
   logic signed [PW-1:0]    s5_puc_ff, s5_phs_ff, s5_phc_ff, s5_pus_ff;
   logic signed [C+1:0]     s5_v_ff;
   status_type              s5_stat_ff;

   // stage 6: depth and vertical axis
   logic                    s6_vld_ff;
   logic signed [C+3:0]     s6_depth_ff, s6_vert_ff, s6_depth_in, s6_vert_in;
   logic signed [C+1:0]     s6_v_ff;
   status_type              s6_stat_ff, s6_stat_in;
   logic signed [PW-1:0]    depth_full, vert_full;

   always_comb begin
      depth_full  = trunc_q14(s5_puc_ff) - trunc_q14(s5_phs_ff);
      vert_full   = trunc_q14(s5_phc_ff) + trunc_q14(s5_pus_ff);
      s6_depth_in = depth_full[C+3:0];
      s6_vert_in  = vert_full[C+3:0];
      s6_stat_in  = s5_stat_ff;
      if (s5_stat_ff == STATUS_PROJECTED && (s6_depth_in[C+3] || s6_depth_in == '0)) begin
         s6_stat_in = STATUS_DEPTH;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_east_ff  <= east;
         s1_north_ff <= north;
         s1_hprod_ff <= s1_hprod_in;
         s1_hneg_ff  <= s1_hneg_in;
         s1_stat_ff  <= s1_stat_in;

         s2_de_ff   <= s2_de_in;
         s2_dn_ff   <= s2_dn_in;
         s2_dh_ff   <= s2_dh_in;
         s2_stat_ff <= s1_stat_ff;

         s3_pes_ff  <= s2_de_ff * sin_y;
         s3_pnc_ff  <= s2_dn_ff * cos_y;
         s3_pec_ff  <= s2_de_ff * cos_y;
         s3_pns_ff  <= s2_dn_ff * sin_y;
         s3_dh_ff   <= s2_dh_ff;
         s3_stat_ff <= s2_stat_ff;

         s4_u_ff    <= s4_u_in;
         s4_v_ff    <= s4_v_in;
         s4_dh_ff   <= s3_dh_ff;
         s4_stat_ff <= s3_stat_ff;

         s5_puc_ff  <= s4_u_ff * cos_p;
         s5_phs_ff  <= s4_dh_ff * sin_p;
         s5_phc_ff  <= s4_dh_ff * cos_p;
         s5_pus_ff  <= s4_u_ff * sin_p;
         s5_v_ff    <= s4_v_ff;
         s5_stat_ff <= s4_stat_ff;

         s6_depth_ff <= s6_depth_in;
         s6_vert_ff  <= s6_vert_in;
         s6_v_ff     <= s5_v_ff;
         s6_stat_ff  <= s6_stat_in;
      end
   end

   assign out_valid  = s6_vld_ff;
   assign lat_out    = s6_v_ff;
   assign vert_out   = s6_vert_ff;
   assign depth_out  = s6_depth_ff;
   assign status_out = s6_stat_ff;

endmodule

[hdl/ppp_div.sv]
// pipelined restoring divider, one quotient bit per stage
module ppp_div
   import ppp_pkg::*;
#(
   parameter int NUM_BITS = 60,
   parameter int DEN_BITS = 43
) (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [NUM_BITS-1:0]   num_in,
   input  logic [DEN_BITS-1:0]   den_in,
   input  logic                  ovf_in,
   output logic [QUOT_BITS-1:0]  quo_out,
   output logic                  ovf_out
);

   localparam int RW = (NUM_BITS > DEN_BITS + QUOT_BITS) ? NUM_BITS : DEN_BITS + QUOT_BITS;

   logic [NUM_BITS-1:0]   rem_ff [QUOT_BITS];
   logic [DEN_BITS-1:0]   den_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0]  quo_ff [QUOT_BITS];
   logic                  ovf_ff [QUOT_BITS];

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
      logic [NUM_BITS-1:0]   rem_prev, rem_in;
      logic [DEN_BITS-1:0]   den_prev;
      logic [QUOT_BITS-1:0]  quo_prev, quo_in;
      logic                  ovf_prev;
      logic [RW-1:0]         rem_w, sub_w;
      logic                  take;

      if (k == 0) begin : g_first
         assign rem_prev = num_in;
         assign den_prev = den_in;
         assign quo_prev = '0;
         assign ovf_prev = ovf_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign ovf_prev = ovf_ff[k-1];
      end

      // compare against the divisor shifted to this quotient bit
      always_comb begin
         rem_w  = RW'(rem_prev);
         sub_w  = RW'(den_prev) << (QUOT_BITS - 1 - k);
         take   = (rem_w >= sub_w);
         rem_in = take ? NUM_BITS'(rem_w - sub_w) : rem_prev;
         quo_in = {quo_prev[QUOT_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
            ovf_ff[k] <= ovf_prev;
         end
      end
   end

   assign quo_out = quo_ff[QUOT_BITS-1];
   assign ovf_out = ovf_ff[QUOT_BITS-1];

endmodule

[hdl/perspective_point_projection_core.sv]
// top level: perspective projection of map points to saturated screen coordinates
// pipeline: geometry stages, numerator stage, overflow stage, one divider stage per
// quotient bit, then the output register; throughput: one transaction per cycle while
// the output is not stalled, as the divider is fully pipelined. a stalled output register holds the whole pipe.
// reset: synchronous, clears all valid bits and loads register defaults.
module perspective_point_projection_core
   import ppp_pkg::*;
#(
   parameter int COORD_BITS  = 32,
   parameter int SCREEN_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_BITS-1:0]   req_east,
   input  logic signed [COORD_BITS-1:0]   req_north,
   input  logic signed [COORD_BITS-1:0]   req_height,
   input  logic                           req_height_null,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SCREEN_BITS-1:0]  rsp_screen_x,
   output logic signed [SCREEN_BITS-1:0]  rsp_screen_y,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]       csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]       csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]       csr_prdata,
   output logic                           csr_pready
);

   localparam int C  = COORD_BITS;
   localparam int NW = C + 4 + FOCAL_BITS;
   localparam int DW = C + 11;
   localparam int RW = (NW > DW + QUOT_BITS) ? NW : DW + QUOT_BITS;
   localparam int SW = QUOT_BITS + 2;
   localparam logic signed [SW-1:0] SCR_HI = SW'((64'd1 << (SCREEN_BITS - 1)) - 64'd1);
   localparam logic signed [SW-1:0] SCR_LO = -SCR_HI - SW'(1);

   logic [63:0]             view_trig;
   logic [C-1:0]            origin_east, origin_north, origin_height;
   logic [FOCAL_BITS-1:0]   focal_scale;
   logic [31:0]             screen_center;
   logic [GAIN_BITS-1:0]    height_gain;
   logic                    draw_null;
   logic                    adv;
   logic                    out_vld_ff;

   // whole pipe advances unless the output register is full and stalled
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   ppp_csr #(.COORD_BITS(C)) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .view_trig     (view_trig),
      .origin_east   (origin_east),
      .origin_north  (origin_north),
      .origin_height (origin_height),
      .focal_scale   (focal_scale),
      .screen_center (screen_center),
      .height_gain   (height_gain),
      .draw_null     (draw_null)
   );

   logic                  fr_vld;
   logic signed [C+1:0]   fr_lat;
   logic signed [C+3:0]   fr_vert, fr_depth;
   status_type            fr_stat;

   ppp_front #(.COORD_BITS(C)) u_front (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .east          (req_east),
      .north         (req_north),
      .height        (req_height),
      .height_null   (req_height_null),
      .view_trig     (view_trig),
      .origin_east   (origin_east),
      .origin_north  (origin_north),
      .origin_height (origin_height),
      .height_gain   (height_gain),
      .draw_null     (draw_null),
      .out_valid     (fr_vld),
      .lat_out       (fr_lat),
      .vert_out      (fr_vert),
      .depth_out     (fr_depth),
      .status_out    (fr_stat)
   );

   // numerator stage: focal times magnitude, divisor is 256 times depth (one if not projected)
   logic                  n1_vld_ff;
   logic [NW-1:0]         n1_numx_ff, n1_numy_ff;
   logic [DW-1:0]         n1_den_ff, n1_den_in;
   side_type              n1_side_ff, n1_side_in;
   logic signed [C+3:0]   lat_w;
   logic [C+3:0]          mag_x, mag_y;

   always_comb begin
      lat_w = fr_lat;
      mag_x = lat_w[C+3] ? (C+4)'(-lat_w) : (C+4)'(lat_w);
      mag_y = fr_vert[C+3] ? (C+4)'(-fr_vert) : (C+4)'(fr_vert);
      n1_den_in = (fr_stat == STATUS_PROJECTED) ? {fr_depth[C+2:0], 8'h00} : DW'(1);
      n1_side_in.status = fr_stat;
      n1_side_in.neg_x  = lat_w[C+3];
      n1_side_in.neg_y  = fr_vert[C+3];
   end

   // overflow stage: quotient would not fit the divider
   logic                  n2_vld_ff;
   logic [NW-1:0]         n2_numx_ff, n2_numy_ff;
   logic [DW-1:0]         n2_den_ff;
   logic                  n2_ovfx_ff, n2_ovfy_ff;
   side_type              n2_side_ff;
   logic [RW-1:0]         den_top;

   assign den_top = RW'(n1_den_ff) << QUOT_BITS;

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_numx_ff <= NW'(focal_scale) * NW'(mag_x);
         n1_numy_ff <= NW'(focal_scale) * NW'(mag_y);
         n1_den_ff  <= n1_den_in;
         n1_side_ff <= n1_side_in;

         n2_numx_ff <= n1_numx_ff;
         n2_numy_ff <= n1_numy_ff;
         n2_den_ff  <= n1_den_ff;
         n2_ovfx_ff <= (RW'(n1_numx_ff) >= den_top);
         n2_ovfy_ff <= (RW'(n1_numy_ff) >= den_top);
         n2_side_ff <= n1_side_ff;
      end
   end

   logic [QUOT_BITS-1:0]  quo_x, quo_y;
   logic                  ovf_x, ovf_y;

   ppp_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_div_x (
      .clock   (clock),
      .adv     (adv),
      .num_in  (n2_numx_ff),
      .den_in  (n2_den_ff),
      .ovf_in  (n2_ovfx_ff),
      .quo_out (quo_x),
      .ovf_out (ovf_x)
   );

   ppp_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_div_y (
      .clock   (clock),
      .adv     (adv),
      .num_in  (n2_numy_ff),
      .den_in  (n2_den_ff),
      .ovf_in  (n2_ovfy_ff),
      .quo_out (quo_y),
      .ovf_out (ovf_y)
   );

   // valid bits and side info alongside the divider
   logic       dv_vld_ff  [QUOT_BITS];
   side_type   dv_side_ff [QUOT_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_vld_ff <= 1'b0;
         n2_vld_ff <= 1'b0;
         for (int k = 0; k < QUOT_BITS; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         n1_vld_ff    <= fr_vld;
         n2_vld_ff    <= n1_vld_ff;
         dv_vld_ff[0] <= n2_vld_ff;
         for (int k = 1; k < QUOT_BITS; k++) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_side_ff[0] <= n2_side_ff;
         for (int k = 1; k < QUOT_BITS; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // center offset and saturation
   side_type                    fin_side;
   logic [QUOT_BITS-1:0]        qmag_x, qmag_y;
   logic signed [SW-1:0]        px, py, cx, cy, sum_x, sum_y;
   logic signed [SCREEN_BITS-1:0] sx_in, sy_in;
   logic [1:0]                  stat_in;

   always_comb begin
      fin_side = dv_side_ff[QUOT_BITS-1];
      qmag_x   = ovf_x ? '1 : quo_x;
      qmag_y   = ovf_y ? '1 : quo_y;
      px       = fin_side.neg_x ? -$signed({2'b00, qmag_x}) : $signed({2'b00, qmag_x});
      py       = fin_side.neg_y ? -$signed({2'b00, qmag_y}) : $signed({2'b00, qmag_y});
      cx       = $signed(screen_center[31:16]);
      cy       = $signed(screen_center[15:0]);
      sum_x    = cx + px;
      sum_y    = cy - py;
      if (sum_x > SCR_HI) sum_x = SCR_HI;
      if (sum_x < SCR_LO) sum_x = SCR_LO;
      if (sum_y > SCR_HI) sum_y = SCR_HI;
      if (sum_y < SCR_LO) sum_y = SCR_LO;
      if (fin_side.status == STATUS_PROJECTED) begin
         sx_in = sum_x[SCREEN_BITS-1:0];
         sy_in = sum_y[SCREEN_BITS-1:0];
      end else begin
         sx_in = '0;
         sy_in = '0;
      end
      stat_in = fin_side.status;
   end

   // output register
   logic signed [SCREEN_BITS-1:0] out_sx_ff, out_sy_ff;
   logic [1:0]                    out_stat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= dv_vld_ff[QUOT_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_sx_ff   <= sx_in;
         out_sy_ff   <= sy_in;
         out_stat_ff <= stat_in;
      end
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_screen_x = out_sx_ff;
   assign rsp_screen_y = out_sy_ff;
   assign rsp_status   = out_stat_ff;

endmodule

[dv/testbench.sv]
// self-checking testbench for the perspective point projection core
module testbench;
   import ppp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 5000;
   localparam int RAND_PER_PHASE = 130;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      status_type         st;
   } screen_point_type;

   typedef struct {
      logic signed [31:0] east;
      logic signed [31:0] north;
      logic signed [31:0] height;
      logic               null_flag;
      bit                 known;
      screen_point_type   result;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_east = '0;
   logic signed [31:0] req_north = '0;
   logic signed [31:0] req_height = '0;
   logic req_height_null = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic [1:0] rsp_status;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   // shadow copy of the view registers
   bit [63:0] view_trig;
   bit [31:0] org_east, org_north, org_height;
   bit [23:0] focal;
   bit [31:0] center;
   bit [15:0] gain;
   bit        draw_null;

   screen_point_type pending_points[$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_req = 0;

   perspective_point_projection_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint mag(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic longint sat_coord(longint a);
      longint lim;
      lim = 64'sd2147483647;
      if (a > lim) return lim;
      if (a < -lim) return -lim;
      return a;
   endfunction

   // product with a q2.14 factor, truncated toward zero
   function automatic longint q14(longint a, logic signed [15:0] t);
      longint tt;
      tt = t;
      return (a * tt) / 16384;
   endfunction

   // focal * a / (256 * depth), magnitude capped at 2^32
   function automatic longint perspective_div(longint a, longint depth);
      longint ua, res, f;
      f = focal;
      if (f == 0) return 0;
      ua = mag(a);
      res = (f * ua) / (256 * depth);
      if (res > 64'sd4294967296) res = 64'sd4294967296;
      return a < 0 ? -res : res;
   endfunction

   function automatic logic signed [15:0] clamp_screen(longint a);
      if (a > 32767) return 16'sh7fff;
      if (a < -32768) return 16'sh8000;
      return a[15:0];
   endfunction

   // expected screen point for one map point under the current view
   function automatic screen_point_type project_point(logic signed [31:0] east,
         logic signed [31:0] north, logic signed [31:0] height, logic null_flag);
      screen_point_type r;
      longint h, hm, de, dn, dh, u, v, depth, vert, cx, cy;
      logic signed [15:0] cp, sp, cyw, syw;
      r = '{x: 0, y: 0, st: STATUS_PROJECTED};
      if (null_flag && !draw_null) begin
         r.st = STATUS_NULL;
         return r;
      end
      h = null_flag ? 0 : longint'(height);
      hm = (mag(h) * longint'(gain)) / 256;
      h = h < 0 ? -hm : hm;
      cp = view_trig[63:48];
      sp = view_trig[47:32];
      cyw = view_trig[31:16];
      syw = view_trig[15:0];
      de = sat_coord(longint'(east) - longint'($signed(org_east)));
      dn = sat_coord(longint'(north) - longint'($signed(org_north)));
      dh = sat_coord(h - longint'($signed(org_height)));
      u = q14(de, syw) + q14(dn, cyw);
      v = q14(de, cyw) - q14(dn, syw);
      depth = q14(u, cp) - q14(dh, sp);
      vert = q14(dh, cp) + q14(u, sp);
      if (depth <= 0) begin
         r.st = STATUS_DEPTH;
         return r;
      end
      cx = longint'($signed(center[31:16]));
      cy = longint'($signed(center[15:0]));
      r.x = clamp_screen(cx + perspective_div(v, depth));
      r.y = clamp_screen(cy - perspective_div(vert, depth));
      return r;
   endfunction

   // one apb write: setup cycle, then access cycle
   task automatic write_reg(reg_index_type idx, bit [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(idx * 8);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_VIEW_TRIG:     view_trig = value;
         REG_ORIGIN_EAST:   org_east = value[31:0];
         REG_ORIGIN_NORTH:  org_north = value[31:0];
         REG_ORIGIN_HEIGHT: org_height = value[31:0];
         REG_FOCAL_SCALE:   focal = value[23:0];
         REG_SCREEN_CENTER: center = value[31:0];
         REG_HEIGHT_GAIN:   gain = value[15:0];
         REG_DRAW_NULL:     draw_null = value[0];
         default: ;
      endcase
   endtask

   // drain the pipe before touching the view
   task automatic wait_drained();
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // offer one point and wait for its transaction; valid stays high afterwards
   task automatic send_point(point_row_type row);
      bit acc;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_east <= row.east;
      req_north <= row.north;
      req_height <= row.height;
      req_height_null <= row.null_flag;
      do begin
         @(negedge clock);
         acc = req_ready;
         @(posedge clock);
      end while (!acc);
      if (row.known) pending_points.push_back(row.result);
      else pending_points.push_back(project_point(row.east, row.north, row.height,
                                                  row.null_flag));
   endtask

   function automatic logic signed [31:0] rand_coord(bit wide);
      if (wide) return $urandom;
      return $signed($urandom_range(4000)) - 2000;
   endfunction

   function automatic bit [15:0] rand_trig();
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= !($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // result checker and watchdog, sampled away from the driving edge
   always @(negedge clock) begin
      screen_point_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (pending_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result x=%0d y=%0d status=%0d",
                           rsp_screen_x, rsp_screen_y, rsp_status);
            end else begin
               want = pending_points.pop_front();
               if (rsp_screen_x !== want.x || rsp_screen_y !== want.y ||
                   rsp_status !== want.st) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected x=%0d y=%0d status=%0d, got x=%0d y=%0d status=%0d",
                              want.x, want.y, want.st, rsp_screen_x, rsp_screen_y,
                              rsp_status);
               end
            end
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      point_row_type dir_rows[13];
      point_row_type row;
      bit wide;
      dir_rows = '{
         '{10, 5, 20, 0, 1, '{2, -4, STATUS_PROJECTED}},
         '{7, 3, -9, 0, 1, '{2, 3, STATUS_PROJECTED}},
         '{-7, 3, 9, 0, 1, '{-2, -3, STATUS_PROJECTED}},
         // zero and negative depth
         '{5, 0, 1, 0, 1, '{0, 0, STATUS_DEPTH}},
         '{5, -4, 1, 0, 1, '{0, 0, STATUS_DEPTH}},
         '{123456, -1, 0, 0, 1, '{0, 0, STATUS_DEPTH}},
         // null height suppressed
         '{1, 2, 3, 1, 1, '{0, 0, STATUS_NULL}},
         '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 1, '{0, 0, STATUS_NULL}},
         // saturation at both ends
         '{32'sh7fffffff, 1, 32'sh80000000, 0, 1, '{16'sh7fff, 16'sh7fff, STATUS_PROJECTED}},
         '{32'sh80000000, 1, 32'sh7fffffff, 0, 1, '{16'sh8000, 16'sh8000, STATUS_PROJECTED}},
         '{0, 32'sh7fffffff, 0, 0, 1, '{0, 0, STATUS_PROJECTED}},
         '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 0, '{0, 0, STATUS_PROJECTED}},
         '{-1000, 7, 5000, 0, 0, '{0, 0, STATUS_PROJECTED}}
      };
      view_trig = 64'h4000_0000_4000_0000;
      org_east = 0; org_north = 0; org_height = 0;
      focal = 24'd256; center = 0; gain = 16'd256; draw_null = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_point(dir_rows[i]);
      req_valid <= 1'b0;

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         case (p)
            0: begin
               write_reg(REG_VIEW_TRIG, 64'hffff_ffff_ffff_ffff);
               write_reg(REG_ORIGIN_EAST, 64'h7fffffff);
               write_reg(REG_ORIGIN_NORTH, 64'h7fffffff);
               write_reg(REG_ORIGIN_HEIGHT, 64'h7fffffff);
               write_reg(REG_FOCAL_SCALE, 64'hffffff);
               write_reg(REG_SCREEN_CENTER, 64'hffff_ffff);
               write_reg(REG_HEIGHT_GAIN, 64'hffff);
               write_reg(REG_DRAW_NULL, 64'd1);
            end
            1: begin
               write_reg(REG_VIEW_TRIG, 64'h8000_8000_8000_8000);
               write_reg(REG_ORIGIN_EAST, 64'h80000000);
               write_reg(REG_ORIGIN_NORTH, 64'h80000000);
               write_reg(REG_ORIGIN_HEIGHT, 64'h80000000);
               write_reg(REG_FOCAL_SCALE, 64'd0);
               write_reg(REG_SCREEN_CENTER, 64'h8000_7fff);
               write_reg(REG_HEIGHT_GAIN, 64'd0);
               write_reg(REG_DRAW_NULL, 64'd0);
            end
            default: begin
               // plausible camera: mostly looking along north, tilted
               write_reg(REG_VIEW_TRIG, {16'($urandom_range(16384, 9000)), rand_trig(),
                                         16'($urandom_range(16384, 6000)), rand_trig()});
               write_reg(REG_ORIGIN_EAST, 64'(rand_coord(p == 7)));
               write_reg(REG_ORIGIN_NORTH, 64'($signed(-$urandom_range(3000))));
               write_reg(REG_ORIGIN_HEIGHT, 64'(rand_coord(p == 7)));
               write_reg(REG_FOCAL_SCALE, p == 6 ? 64'($urandom & 24'hffffff)
                                                 : 64'($urandom_range(200000)));
               write_reg(REG_SCREEN_CENTER, 64'({16'($urandom_range(1000)),
                                                 16'($urandom_range(800))}));
               write_reg(REG_HEIGHT_GAIN, 64'($urandom_range(1024)));
               write_reg(REG_DRAW_NULL, 64'(p % 2));
            end
         endcase
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         if (p == 4) hold_req = 1;
         for (int k = 0; k < RAND_PER_PHASE; k++) begin
            wide = ($urandom_range(3) == 0);
            row.east = rand_coord(wide);
            row.north = wide ? $urandom : $urandom_range(3000);
            row.height = rand_coord(wide);
            row.null_flag = ($urandom_range(9) == 0);
            row.known = 0;
            send_point(row);
         end
         req_valid <= 1'b0;
      end

      // let the pipe empty out
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

[sim.f]
hdl/ppp_pkg.sv
hdl/ppp_csr.sv
hdl/ppp_front.sv
hdl/ppp_div.sv
hdl/perspective_point_projection_core.sv
dv/testbench.sv
